@@ rtl/yrgb_pkg.sv @@
// shared constants, types and helpers for the yuv 4:2:2 to rgb pair converter
`default_nettype none
package yrgb_pkg;

	// byte order codes
	localparam logic ORDER_YUYV = 1'b0;
	localparam logic ORDER_UYVY = 1'b1;

	// q15 chroma coefficients
	localparam logic [16:0] CoefRv = 17'd37221;
	localparam logic [16:0] CoefGu = 17'd12975;
	localparam logic [16:0] CoefGv = 17'd18949;
	localparam logic [16:0] CoefBu = 17'd66883;
	localparam logic [7:0]  ChromaMid = 8'd128;
	localparam int unsigned FracBits = 15;

	typedef logic signed [8:0]  chroma_t;
	typedef logic signed [25:0] prod_t;
	typedef logic signed [9:0]  offset_t;
	typedef logic signed [10:0] chan_t;

	typedef struct packed {
		offset_t red;
		offset_t green;
		offset_t blue;
	} offsets_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// clamp a widened channel to 0..255
	function automatic logic [7:0] sat8(input chan_t x);
		logic [7:0] r;
		if (x < 0) begin
			r = 8'd0;
		end else if (x > 11'sd255) begin
			r = 8'd255;
		end else begin
			r = x[7:0];
		end
		return r;
	endfunction

	// centre an unsigned chroma byte
	function automatic chroma_t centre(input logic [7:0] c);
		return $signed({1'b0, c}) - $signed({1'b0, ChromaMid});
	endfunction

endpackage
`default_nettype wire

@@ rtl/yrgb_chroma.sv @@
// shared chroma products and per-channel luma offsets, two pipeline stages
`default_nettype none
module yrgb_chroma (
	input  wire logic             clk,
	input  wire logic             en_s2,
	input  wire logic             en_s3,
	input  wire yrgb_pkg::chroma_t du,
	input  wire yrgb_pkg::chroma_t dv,
	output yrgb_pkg::offsets_t    offsets
);
	import yrgb_pkg::*;

	prod_t p_rv_s2;
	prod_t p_gu_s2;
	prod_t p_gv_s2;
	prod_t p_bu_s2;
	prod_t g_sum;
	prod_t r_shift;
	prod_t g_shift;
	prod_t b_shift;
	offsets_t off_s3;

	// one multiply per coefficient, registered
	always_ff @(posedge clk) begin
		if (en_s2) begin
			p_rv_s2 <= prod_t'(dv) * prod_t'($signed({1'b0, CoefRv}));
			p_gu_s2 <= prod_t'(du) * prod_t'($signed({1'b0, CoefGu}));
			p_gv_s2 <= prod_t'(dv) * prod_t'($signed({1'b0, CoefGv}));
			p_bu_s2 <= prod_t'(du) * prod_t'($signed({1'b0, CoefBu}));
		end
	end

	// arithmetic shift gives the floor of the q15 product
	always_comb begin
		g_sum   = p_gu_s2 + p_gv_s2;
		r_shift = p_rv_s2 >>> FracBits;
		g_shift = g_sum >>> FracBits;
		b_shift = p_bu_s2 >>> FracBits;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			off_s3.red   <= r_shift[9:0];
			off_s3.green <= g_shift[9:0];
			off_s3.blue  <= b_shift[9:0];
		end
	end

	assign offsets = off_s3;

endmodule
`default_nettype wire

@@ rtl/yrgb_lane.sv @@
// one pixel lane: luma plus chroma offsets, saturated to eight bits
`default_nettype none
module yrgb_lane (
	input  wire logic [7:0]         luma,
	input  wire yrgb_pkg::offsets_t offsets,
	output yrgb_pkg::rgb_t          rgb
);
	import yrgb_pkg::*;

	chan_t y_w;
	chan_t r_w;
	chan_t g_w;
	chan_t b_w;

	always_comb begin
		y_w = $signed({3'b000, luma});
		r_w = y_w + chan_t'(offsets.red);
		g_w = y_w - chan_t'(offsets.green);
		b_w = y_w + chan_t'(offsets.blue);
		rgb.red   = sat8(r_w);
		rgb.green = sat8(g_w);
		rgb.blue  = sat8(b_w);
	end

endmodule
`default_nettype wire

@@ rtl/yuv422_to_rgb_pair.sv @@
// top level: packed 4:2:2 macropixel in, two rgb888 pixels out
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  input   | in_valid / in_stall | first_byte..fourth_byte, last_in
//  output  | out_valid/out_stall | first_/second_ red, green, blue, last_out
//  config  | cfg_valid/cfg_ready | cfg_data (byte order, 0 = yuyv, 1 = uyvy)
//
// one item per clock sustained while out_stall stays low
// each item passes the unpack, chroma multiply, shift/sum and lane/output stages
// each stage loads when empty or when the stage after it moves on, so
// bubbles close up and a stalled result only holds back the full stages
// arst_n clears the valid flags and the byte order register
`default_nettype none
module yuv422_to_rgb_pair (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,
	// input item
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] first_byte,
	input  wire logic [7:0] second_byte,
	input  wire logic [7:0] third_byte,
	input  wire logic [7:0] fourth_byte,
	input  wire logic       last_in,
	// result item
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      first_red,
	output logic [7:0]      first_green,
	output logic [7:0]      first_blue,
	output logic [7:0]      second_red,
	output logic [7:0]      second_green,
	output logic [7:0]      second_blue,
	output logic            last_out
);
	import yrgb_pkg::*;

	logic byte_order_q;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	// stage 1: unpacked samples
	logic [7:0] y0_s1, y1_s1;
	chroma_t    du_s1, dv_s1;
	logic       last_s1;

	// luma and flag travel alongside the chroma stages
	logic [7:0] y0_s2, y1_s2, y0_s3, y1_s3;
	logic       last_s2, last_s3, last_s4;

	logic [7:0] y0_w, y1_w, u_w, v_w;
	offsets_t   offsets_w;
	rgb_t       rgb0_w, rgb1_w;
	rgb_t       rgb0_s4, rgb1_s4;

	// configuration register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q <= ORDER_YUYV;
		end else if (cfg_valid && cfg_ready) begin
			byte_order_q <= cfg_data;
		end
	end

	// backpressure chain from the output register back to the input
	assign rdy_s4   = !v_s4 || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// byte order select
	always_comb begin
		case (byte_order_q)
			ORDER_UYVY: begin
				u_w  = first_byte;
				y0_w = second_byte;
				v_w  = third_byte;
				y1_w = fourth_byte;
			end
			default: begin
				y0_w = first_byte;
				u_w  = second_byte;
				y1_w = third_byte;
				v_w  = fourth_byte;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			y0_s1   <= y0_w;
			y1_s1   <= y1_w;
			du_s1   <= centre(u_w);
			dv_s1   <= centre(v_w);
			last_s1 <= last_in;
		end
		if (rdy_s2) begin
			y0_s2   <= y0_s1;
			y1_s2   <= y1_s1;
			last_s2 <= last_s1;
		end
		if (rdy_s3) begin
			y0_s3   <= y0_s2;
			y1_s3   <= y1_s2;
			last_s3 <= last_s2;
		end
	end

	// shared chroma path, stages 2 and 3
	yrgb_chroma u_chroma (
		.clk     (clk),
		.en_s2   (rdy_s2),
		.en_s3   (rdy_s3),
		.du      (du_s1),
		.dv      (dv_s1),
		.offsets (offsets_w)
	);

	// two pixel lanes share the offsets
	yrgb_lane u_lane0 (
		.luma    (y0_s3),
		.offsets (offsets_w),
		.rgb     (rgb0_w)
	);

	yrgb_lane u_lane1 (
		.luma    (y1_s3),
		.offsets (offsets_w),
		.rgb     (rgb1_w)
	);

	// merge both lanes into the output register
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			rgb0_s4 <= rgb0_w;
			rgb1_s4 <= rgb1_w;
			last_s4 <= last_s3;
		end
	end

	assign out_valid    = v_s4;
	assign first_red    = rgb0_s4.red;
	assign first_green  = rgb0_s4.green;
	assign first_blue   = rgb0_s4.blue;
	assign second_red   = rgb1_s4.red;
	assign second_green = rgb1_s4.green;
	assign second_blue  = rgb1_s4.blue;
	assign last_out     = last_s4;

endmodule
`default_nettype wire

@@ test/yuv422_checker.sv @@
// result checker for the yuv 4:2:2 to rgb pair converter: predicts each pixel pair and compares
`timescale 1ns / 100ps
module yuv422_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic       cfg_data,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [7:0] first_byte,
	input  wire logic [7:0] second_byte,
	input  wire logic [7:0] third_byte,
	input  wire logic [7:0] fourth_byte,
	input  wire logic       last_in,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [7:0] first_red,
	input  wire logic [7:0] first_green,
	input  wire logic [7:0] first_blue,
	input  wire logic [7:0] second_red,
	input  wire logic [7:0] second_green,
	input  wire logic [7:0] second_blue,
	input  wire logic       last_out,
	output int              fail_count,
	output int              pairs_due
);
	import yrgb_pkg::*;

	typedef struct packed {
		rgb_t px0;
		rgb_t px1;
		logic frame_end;
	} pixel_pair_t;

	pixel_pair_t pending_pairs[$];
	pixel_pair_t want;
	logic        byte_order;
	int          fail_total = 0;
	int          due_total = 0;

	assign fail_count = fail_total;
	assign pairs_due  = due_total;

	function automatic logic [7:0] clamp_u8(input int x);
		if (x < 0) begin
			return 8'd0;
		end else if (x > 255) begin
			return 8'd255;
		end
		return x[7:0];
	endfunction

	// arithmetic shift gives the floor for negative chroma products
	function automatic rgb_t convert_pixel(input logic [7:0] luma, input int du, input int dv);
		int   y;
		rgb_t p;
		y       = int'(luma);
		p.red   = clamp_u8(y + ((dv * int'(CoefRv)) >>> FracBits));
		p.green = clamp_u8(y - ((du * int'(CoefGu) + dv * int'(CoefGv)) >>> FracBits));
		p.blue  = clamp_u8(y + ((du * int'(CoefBu)) >>> FracBits));
		return p;
	endfunction

	function automatic pixel_pair_t predict_pair(input logic order, input logic [7:0] b0,
			input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3,
			input logic frame_end);
		logic [7:0]  y0, y1, u, v;
		int          du, dv;
		pixel_pair_t r;
		if (order == ORDER_YUYV) begin
			y0 = b0; u = b1; y1 = b2; v = b3;
		end else begin
			u = b0; y0 = b1; v = b2; y1 = b3;
		end
		du          = int'(u) - int'(ChromaMid);
		dv          = int'(v) - int'(ChromaMid);
		r.px0       = convert_pixel(y0, du, dv);
		r.px1       = convert_pixel(y1, du, dv);
		r.frame_end = frame_end;
		return r;
	endfunction

	task automatic note_field(input string field, input logic [7:0] exp_val,
			input logic [7:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, exp_val, got_val);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order = ORDER_YUYV;
			pending_pairs.delete();
			due_total = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				byte_order = cfg_data;
			end
			if (in_valid && !in_stall) begin
				pending_pairs.push_back(predict_pair(byte_order, first_byte, second_byte,
						third_byte, fourth_byte, last_in));
			end
			if (out_valid && !out_stall) begin
				if (pending_pairs.size() == 0) begin
					$display("%0t: result with none expected, got rgb %0d/%0d/%0d",
							$time, first_red, first_green, first_blue);
					fail_total++;
				end else begin
					want = pending_pairs.pop_front();
					note_field("first_red", want.px0.red, first_red);
					note_field("first_green", want.px0.green, first_green);
					note_field("first_blue", want.px0.blue, first_blue);
					note_field("second_red", want.px1.red, second_red);
					note_field("second_green", want.px1.green, second_green);
					note_field("second_blue", want.px1.blue, second_blue);
					note_field("last_out", {7'd0, want.frame_end}, {7'd0, last_out});
				end
			end
			due_total = pending_pairs.size();
		end
	end
endmodule

@@ test/tb.sv @@
// testbench top for the yuv 4:2:2 to rgb pair converter: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb;
	import yrgb_pkg::*;

	// long receiver hold-off, long enough to fill every pipeline stage
	localparam int LongHold    = 300;
	// pause after the last expected result, so the four-stage pipeline goes quiet
	localparam int DrainCycles = 8;
	localparam int PhaseItems  = 100;
	localparam int PhaseCount  = 6;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] first_byte = 8'd0;
	logic [7:0] second_byte = 8'd0;
	logic [7:0] third_byte = 8'd0;
	logic [7:0] fourth_byte = 8'd0;
	logic       last_in = 1'b0;
	logic       out_stall = 1'b1;

	wire logic       cfg_ready;
	wire logic       in_stall;
	wire logic       out_valid;
	wire logic [7:0] first_red, first_green, first_blue;
	wire logic [7:0] second_red, second_green, second_blue;
	wire logic       last_out;

	int fail_count;
	int pairs_due;

	// idling modes, changed by the stimulus between phases
	logic tx_steady = 1'b0;
	logic rx_steady = 1'b0;
	logic long_hold_req = 1'b0;

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	yuv422_to_rgb_pair DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first_byte   (first_byte),
		.second_byte  (second_byte),
		.third_byte   (third_byte),
		.fourth_byte  (fourth_byte),
		.last_in      (last_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.first_red    (first_red),
		.first_green  (first_green),
		.first_blue   (first_blue),
		.second_red   (second_red),
		.second_green (second_green),
		.second_blue  (second_blue),
		.last_out     (last_out)
	);

	yuv422_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first_byte   (first_byte),
		.second_byte  (second_byte),
		.third_byte   (third_byte),
		.fourth_byte  (fourth_byte),
		.last_in      (last_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.first_red    (first_red),
		.first_green  (first_green),
		.first_blue   (first_blue),
		.second_red   (second_red),
		.second_green (second_green),
		.second_blue  (second_blue),
		.last_out     (last_out),
		.fail_count   (fail_count),
		.pairs_due    (pairs_due)
	);

	// bytes biased towards the saturation corners and the chroma midpoint
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: begin
				return 8'd0;
			end
			1: begin
				return 8'd255;
			end
			2: begin
				return 8'd128;
			end
			3: begin
				return 8'd127;
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic push_macropixel(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic frame_end);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		first_byte  <= b0;
		second_byte <= b1;
		third_byte  <= b2;
		fourth_byte <= b3;
		last_in     <= frame_end;
		// payload held until the block takes it
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_byte_order(input logic order);
		cfg_valid <= 1'b1;
		cfg_data  <= order;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid and wait for every expected pair, then let the pipeline go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (pairs_due != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// corners of the conversion, read as y0 u y1 v in yuyv order and u y0 v y1 in uyvy
	task automatic run_directed();
		push_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		push_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		push_macropixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
		push_macropixel(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
		push_macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
		push_macropixel(8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
		push_macropixel(8'd255, 8'd255, 8'd0, 8'd0, 1'b0);
		push_macropixel(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
		// chroma just below the midpoint, where the shift must floor
		push_macropixel(8'd127, 8'd127, 8'd128, 8'd129, 1'b0);
		push_macropixel(8'd1, 8'd129, 8'd254, 8'd127, 1'b1);
		push_macropixel(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b0);
		push_macropixel(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1);
	endtask

	// receiver: a fresh random hold-off for every item, none in steady mode, or one long stretch on request
	initial begin : receiver
		int hold;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				hold = LongHold;
				long_hold_req <= 1'b0;
			end else if (rx_steady) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 6);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int phase;
		int k;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners in both byte orders
		write_byte_order(ORDER_YUYV);
		run_directed();
		settle();
		write_byte_order(ORDER_UYVY);
		run_directed();
		settle();

		// random phases, alternating byte order and idling mode
		for (phase = 0; phase < PhaseCount; phase++) begin
			write_byte_order(phase[0] ? ORDER_UYVY : ORDER_YUYV);
			tx_steady <= (phase == 1 || phase == 3);
			rx_steady <= (phase == 2 || phase == 3);
			// back-pressure phase: sender keeps offering while the receiver holds off
			if (phase == 3) begin
				long_hold_req <= 1'b1;
			end
			@(negedge clk);
			for (k = 0; k < PhaseItems; k++) begin
				push_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
						$urandom_range(0, 9) == 0);
			end
			settle();
		end

		if (fail_count == 0 && pairs_due == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#400000;
		$display("tb: failure");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/yrgb_pkg.sv
rtl/yrgb_chroma.sv
rtl/yrgb_lane.sv
rtl/yuv422_to_rgb_pair.sv
test/yuv422_checker.sv
test/tb.sv
